// ----- hw/rtl/brb_pkg.sv -----
// Shared types and constants for the byte ring buffer with chunk drain.
// Used by brb_ctrl, brb_dpath and the top level; no dependencies.
package brb_pkg;

  localparam int OP_W      = 3;
  localparam int BYTE_W    = 8;
  localparam int OFF_W     = 10;
  localparam int CNT_FLD_W = 11;
  localparam int ADDR_W    = 10;
  localparam int SIZE_W    = 4;

  localparam logic [SIZE_W-1:0] SIZE_LOG2_RESET = 4'd10;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_DELETE = 3'd3,
    OP_DMA    = 3'd4
  } op_t;

  typedef struct packed {
    logic load;   // capture the incoming item
    logic exec;   // run the captured item against buffer state
    logic clear;  // size register write, pointers cleared
  } cmd_t;

endpackage

// ----- hw/rtl/brb_ctrl.sv -----
// Controller for the byte ring buffer: item handshake sequencing.
// Depends on brb_pkg (cmd_t); drives commands into brb_dpath.
module brb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  output brb_pkg::cmd_t cmd
);
  import brb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_OUT
  } state_t;

  state_t state;

  always_comb begin
    cmd.load  = (state == ST_IDLE) && in_valid && !in_stall;
    cmd.exec  = (state == ST_EXEC);
    cmd.clear = cfg_valid && cfg_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_stall  <= 1'b1;
      out_valid <= 1'b0;
      cfg_ready <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid && !in_stall) begin
            state     <= ST_EXEC;
            in_stall  <= 1'b1;
            cfg_ready <= 1'b0;
          end else begin
            in_stall  <= 1'b0;
            cfg_ready <= 1'b1;
          end
        end
        ST_EXEC: begin
          state     <= ST_OUT;
          out_valid <= 1'b1;
        end
        ST_OUT: begin
          if (!out_stall) begin
            state     <= ST_IDLE;
            out_valid <= 1'b0;
            in_stall  <= 1'b0;
            cfg_ready <= 1'b1;
          end
        end
        default: begin
          state     <= ST_IDLE;
          in_stall  <= 1'b1;
          out_valid <= 1'b0;
          cfg_ready <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/brb_dpath.sv -----
// Datapath for the byte ring buffer: byte memory, pointers, fill count,
// pending chunk and result registers. Depends on brb_pkg.
module brb_dpath #(
  parameter int DEPTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  brb_pkg::cmd_t                   cmd,
  input  logic [brb_pkg::SIZE_W-1:0]      size_log2,
  input  logic [brb_pkg::OP_W-1:0]        op,
  input  logic [brb_pkg::BYTE_W-1:0]      data_in,
  input  logic [brb_pkg::OFF_W-1:0]       offset,
  input  logic [brb_pkg::CNT_FLD_W-1:0]   count,
  output logic                            ok,
  output logic [brb_pkg::BYTE_W-1:0]      data_out,
  output logic [brb_pkg::CNT_FLD_W-1:0]   done_count,
  output logic [brb_pkg::ADDR_W-1:0]      start_addr,
  output logic [brb_pkg::CNT_FLD_W-1:0]   fill_level,
  output logic [brb_pkg::CNT_FLD_W-1:0]   headroom
);
  import brb_pkg::*;

  // largest power of two that fits in DEPTH
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH + 1) - 1 : 1;
  localparam int MEM_D = 1 << PTR_W;
  localparam int CNT_W = PTR_W + 1;
  localparam int CMP_W = (CNT_W > CNT_FLD_W) ? CNT_W : CNT_FLD_W;

  logic [BYTE_W-1:0] mem [MEM_D];

  logic [SIZE_W-1:0]  size_reg;
  logic [PTR_W-1:0]   write_ptr, read_ptr;
  logic [CNT_W-1:0]   fill_count, dma_pending;

  logic [OP_W-1:0]    op_q;
  logic [BYTE_W-1:0]  din_q;
  logic [OFF_W-1:0]   off_q;
  logic [CNT_FLD_W-1:0] cnt_q;

  logic               ok_q, rd_ok_q;
  logic [BYTE_W-1:0]  rd_data;
  logic [CNT_W-1:0]   done_q, fill_q, head_q;
  logic [PTR_W-1:0]   start_q;

  logic [4:0]         lvl;
  logic [CNT_W-1:0]   size_c;
  logic [PTR_W-1:0]   mask;

  logic [PTR_W-1:0]   write_ptr_next, read_ptr_next, raddr, start_c;
  logic [CNT_W-1:0]   fill_count_next, dma_pending_next, done_c, chunk;
  logic [CMP_W-1:0]   req_c;
  logic               ok_c, we, re;

  always_comb begin
    lvl = {1'b0, size_reg};
    if (lvl == 5'd0) lvl = 5'd1;
    if (lvl > 5'(PTR_W)) lvl = 5'(PTR_W);
    size_c = CNT_W'(1) << lvl;
    mask   = size_c[PTR_W-1:0] - PTR_W'(1);
  end

  always_comb begin
    write_ptr_next   = write_ptr;
    read_ptr_next    = read_ptr;
    fill_count_next  = fill_count;
    dma_pending_next = dma_pending;
    ok_c    = 1'b0;
    done_c  = '0;
    start_c = '0;
    we      = 1'b0;
    re      = 1'b0;
    raddr   = read_ptr;
    req_c   = '0;
    chunk   = '0;
    case (op_q)
      OP_PUSH: begin
        if (fill_count < size_c) begin
          we              = 1'b1;
          write_ptr_next  = (write_ptr + PTR_W'(1)) & mask;
          fill_count_next = fill_count + CNT_W'(1);
          ok_c            = 1'b1;
        end
      end
      OP_POP: begin
        if (fill_count != '0) begin
          re              = 1'b1;
          read_ptr_next   = (read_ptr + PTR_W'(1)) & mask;
          fill_count_next = fill_count - CNT_W'(1);
          ok_c            = 1'b1;
        end
      end
      OP_PEEK: begin
        if (CMP_W'(off_q) < CMP_W'(fill_count)) begin
          re    = 1'b1;
          raddr = (read_ptr + PTR_W'(off_q)) & mask;
          ok_c  = 1'b1;
        end
      end
      OP_DELETE: begin
        req_c  = (dma_pending != '0) ? CMP_W'(dma_pending) : CMP_W'(cnt_q);
        done_c = (req_c > CMP_W'(fill_count)) ? fill_count : CNT_W'(req_c);
        dma_pending_next = '0;
        fill_count_next  = fill_count - done_c;
        read_ptr_next    = (read_ptr + PTR_W'(done_c)) & mask;
        ok_c             = (done_c != '0);
      end
      OP_DMA: begin
        chunk            = size_c - CNT_W'(read_ptr);
        done_c           = (chunk > fill_count) ? fill_count : chunk;
        dma_pending_next = done_c;
        start_c          = read_ptr;
        ok_c             = (done_c != '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg    <= SIZE_LOG2_RESET;
      write_ptr   <= '0;
      read_ptr    <= '0;
      fill_count  <= '0;
      dma_pending <= '0;
    end else if (cmd.clear) begin
      size_reg    <= size_log2;
      write_ptr   <= '0;
      read_ptr    <= '0;
      fill_count  <= '0;
      dma_pending <= '0;
    end else if (cmd.exec) begin
      write_ptr   <= write_ptr_next;
      read_ptr    <= read_ptr_next;
      fill_count  <= fill_count_next;
      dma_pending <= dma_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= op;
      din_q <= data_in;
      off_q <= offset;
      cnt_q <= count;
    end
    if (cmd.exec) begin
      ok_q    <= ok_c;
      rd_ok_q <= re;
      done_q  <= done_c;
      start_q <= start_c;
      fill_q  <= fill_count_next;
      head_q  <= size_c - fill_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && we) mem[write_ptr] <= din_q;
    if (cmd.exec && re) rd_data <= mem[raddr];
  end

  assign ok         = ok_q;
  assign data_out   = rd_ok_q ? rd_data : '0;
  assign done_count = CNT_FLD_W'(done_q);
  assign start_addr = ADDR_W'(start_q);
  assign fill_level = CNT_FLD_W'(fill_q);
  assign headroom   = CNT_FLD_W'(head_q);

endmodule

// ----- hw/rtl/byte_ring_buffer_with_dma_drain_core.sv -----
// Top level of the byte ring buffer with chunk drain.
// Instantiates brb_ctrl and brb_dpath; depends on brb_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one item: op, data_in,
//   offset, count. Ops: push, pop, peek, delete, chunk prepare.
//   Output channel (out_valid/out_stall) returns one result per item:
//   ok, data_out, done_count, start_addr, fill_level, headroom.
//   Config channel (cfg_valid/cfg_ready) writes size_log2 and clears the
//   pointers, fill count and pending chunk; stored bytes are kept.
//   An accepted item is registered, executed in the execute state with a
//   registered memory read, and its result is delivered in the output
//   state; no new item is taken until that result has been delivered.
//   Only one item is in flight; while the output is stalled the result
//   holds and in_stall stays high.
//   Reset (rst, synchronous) clears pointers and counts, sets size_log2
//   to 10 (clamped to DEPTH); memory contents are not cleared. in_stall
//   is high for one cycle after reset.
module byte_ring_buffer_with_dma_drain_core #(
  parameter int DEPTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [brb_pkg::OP_W-1:0]        op,
  input  logic [brb_pkg::BYTE_W-1:0]      data_in,
  input  logic [brb_pkg::OFF_W-1:0]       offset,
  input  logic [brb_pkg::CNT_FLD_W-1:0]   count,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            ok,
  output logic [brb_pkg::BYTE_W-1:0]      data_out,
  output logic [brb_pkg::CNT_FLD_W-1:0]   done_count,
  output logic [brb_pkg::ADDR_W-1:0]      start_addr,
  output logic [brb_pkg::CNT_FLD_W-1:0]   fill_level,
  output logic [brb_pkg::CNT_FLD_W-1:0]   headroom,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [brb_pkg::SIZE_W-1:0]      size_log2
);
  import brb_pkg::*;

  cmd_t cmd;

  brb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  brb_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .size_log2  (size_log2),
    .op         (op),
    .data_in    (data_in),
    .offset     (offset),
    .count      (count),
    .ok         (ok),
    .data_out   (data_out),
    .done_count (done_count),
    .start_addr (start_addr),
    .fill_level (fill_level),
    .headroom   (headroom)
  );

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("item accepted while a result is pending");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> ##2 out_valid)
    else $error("result not presented two cycles after accept");

  a_no_cfg_while_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid || $past(in_valid && !in_stall)) |-> !cfg_ready)
    else $error("config port open while an item is in flight");

  a_level_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot(12'(fill_level) + 12'(headroom)))
    else $error("fill level and headroom do not sum to the buffer size");

endmodule
